// ----- hdl/iim_pkg.sv -----
// shared types and constants for the interval interference matrix
package iim_pkg;

	// field widths fixed by the item formats
	localparam int unsigned POS_IN_W  = 16;
	localparam int unsigned CNT_W     = 7;
	localparam int unsigned ROW_IDX_W = 6;
	localparam int unsigned ROW_W     = 64;

	// defaults for the top level parameters
	localparam int unsigned VREG_DEPTH_DEF = 64;
	localparam int unsigned POS_WIDTH_DEF  = 16;

	// reset value of the register count
	localparam logic [CNT_W-1:0] VREG_COUNT_RST = 7'd64;

	// one live-interval record
	typedef struct packed {
		logic [POS_IN_W-1:0] live_start;
		logic [POS_IN_W-1:0] live_end;
		logic                has_interval;
		logic                live_in;
	} in_item_t;

	// one adjacency row
	typedef struct packed {
		logic [ROW_IDX_W-1:0] row_index;
		logic [ROW_W-1:0]     row_bits;
		logic                 last_row;
	} out_item_t;

endpackage

// ----- hdl/iim_ram.sv -----
// generic single write port ram with registered read
module iim_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/interval_interference_matrix.sv -----
// interference graph builder: loads live intervals, emits one adjacency row per register
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid / in_ready    | in_data: live_start, live_end, has_interval, live_in
//  out     | out_valid / out_ready  | out_data: row_index, row_bits, last_row
//  cfg     | cfg_valid / cfg_ready  | cfg_data: vreg_count
//
// each accepted record is written into the interval ram; the record that completes the graph starts emission
// each row reads the row's own interval, latches it, then compares one stored interval
// per cycle through the single ram read port and the one overlap compare unit, and
// then holds the finished row until out_ready takes it
// in_ready and cfg_ready are low from the completing record until the last row is taken
// the interval ram needs no clearing pass after reset; only entries already loaded are read
module interval_interference_matrix #(
	parameter int unsigned VREG_DEPTH = iim_pkg::VREG_DEPTH_DEF,
	parameter int unsigned POS_WIDTH  = iim_pkg::POS_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  iim_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output iim_pkg::out_item_t             out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [iim_pkg::CNT_W-1:0]      cfg_data
);

	localparam int unsigned IDX_W = $clog2(VREG_DEPTH);
	localparam int unsigned ENT_W = 2 * POS_WIDTH + 2;
	localparam int unsigned CNT_W = iim_pkg::CNT_W;

	// stored entry layout
	typedef struct packed {
		logic [POS_WIDTH-1:0] start_pos;
		logic [POS_WIDTH-1:0] end_pos;
		logic                 valid;
		logic                 livein;
	} entry_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_BASE,
		S_LATCH,
		S_SCAN,
		S_OUT
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         vreg_count_q;
	logic [CNT_W-1:0]         load_count_q;
	logic [IDX_W-1:0]         row_q;
	logic [IDX_W-1:0]         col_q;
	entry_t                   base_q;
	logic [iim_pkg::ROW_W-1:0] bits_q;
	logic                     out_valid_q;

	logic [CNT_W-1:0]         n_eff;
	logic [CNT_W-1:0]         n_last;
	logic [CNT_W-1:0]         load_next;
	logic                     in_acc;
	logic                     wr_en;
	entry_t                   wr_entry;
	logic [IDX_W-1:0]         rd_addr;
	logic [ENT_W-1:0]         rd_word;
	entry_t                   rd_entry;
	logic                     col_last;
	logic                     row_last;
	logic                     hit;

	// effective count: zero acts as one, above the store depth acts as the depth
	always_comb begin
		if (vreg_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (vreg_count_q > CNT_W'(VREG_DEPTH)) begin
			n_eff = CNT_W'(VREG_DEPTH);
		end else begin
			n_eff = vreg_count_q;
		end
	end

	assign n_last    = n_eff - CNT_W'(1);
	assign in_ready  = (state_q == S_LOAD);
	assign cfg_ready = (state_q == S_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign load_next = load_count_q + CNT_W'(1);

	// record write into the interval ram
	assign wr_en                 = in_acc && (load_count_q < CNT_W'(VREG_DEPTH));
	assign wr_entry.start_pos    = POS_WIDTH'(in_data.live_start);
	assign wr_entry.end_pos      = POS_WIDTH'(in_data.live_end);
	assign wr_entry.valid        = in_data.has_interval;
	assign wr_entry.livein       = in_data.live_in;

	// scan position flags
	assign col_last = (CNT_W'(col_q) == n_last);
	assign row_last = (CNT_W'(row_q) == n_last);

	// read address: own entry, then one column per cycle
	always_comb begin
		case (state_q)
			S_BASE:  rd_addr = row_q;
			S_LATCH: rd_addr = '0;
			S_SCAN:  rd_addr = col_last ? '0 : col_q + IDX_W'(1);
			default: rd_addr = '0;
		endcase
	end

	iim_ram #(
		.WIDTH(ENT_W),
		.DEPTH(VREG_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(load_count_q[IDX_W-1:0]),
		.wdata(wr_entry),
		.raddr(rd_addr),
		.rdata(rd_word)
	);

	assign rd_entry = entry_t'(rd_word);

	// shared overlap and live-in compare
	always_comb begin
		hit = (base_q.valid && rd_entry.valid &&
			(base_q.start_pos <= rd_entry.end_pos) &&
			(rd_entry.start_pos <= base_q.end_pos)) ||
			(base_q.livein && rd_entry.livein);
		if (col_q == row_q) begin
			hit = 1'b0;
		end
	end

	// sequencer with load count, config register and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			vreg_count_q <= iim_pkg::VREG_COUNT_RST;
			load_count_q <= '0;
			row_q        <= '0;
			col_q        <= '0;
			base_q       <= '0;
			bits_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vreg_count_q <= cfg_data;
			end
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (load_next >= n_eff) begin
							load_count_q <= '0;
							row_q        <= '0;
							state_q      <= S_BASE;
						end else begin
							load_count_q <= load_next;
						end
					end
				end
				S_BASE: begin
					state_q <= S_LATCH;
				end
				S_LATCH: begin
					base_q  <= rd_entry;
					bits_q  <= '0;
					col_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					bits_q[iim_pkg::ROW_IDX_W'(col_q)] <= hit;
					if (col_last) begin
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						col_q <= col_q + IDX_W'(1);
					end
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (row_last) begin
							state_q <= S_LOAD;
						end else begin
							row_q   <= row_q + IDX_W'(1);
							state_q <= S_BASE;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// result payload
	assign out_valid          = out_valid_q;
	assign out_data.row_index = iim_pkg::ROW_IDX_W'(row_q);
	assign out_data.row_bits  = bits_q;
	assign out_data.last_row  = row_last;

	// the diagonal of every emitted row is clear
	a_diag_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.row_bits[out_data.row_index] == 1'b0))
		else $error("diagonal bit set");

	// no bit at or above the register count
	a_upper_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.row_bits >> n_eff) == '0))
		else $error("row bit beyond register count");

	// the emitted row index stays below the register count
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CNT_W'(out_data.row_index) < n_eff))
		else $error("row index out of range");

	// loading and emission never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a row is shown");

	// a completing record starts emission of row zero
	a_start_row0: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (load_next >= n_eff)) |=> (!in_ready && (row_q == '0)))
		else $error("emission did not start at row zero");

endmodule

// ----- sim/interval_interference_matrix_test.sv -----
// self-checking testbench for the interval interference matrix: random records, row checks
`timescale 1ns / 100ps

module interval_interference_matrix_test;

	localparam int unsigned VREG_LIMIT = iim_pkg::VREG_DEPTH_DEF;
	localparam int unsigned RECORD_TARGET = 460;
	localparam int unsigned QUIET_AFTER = 400;
	localparam int unsigned SETTLE_CYCLES = 20;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	iim_pkg::in_item_t           in_data = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	iim_pkg::out_item_t          out_data;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [iim_pkg::CNT_W-1:0]   cfg_data = '0;

	// pending records and the rows they are expected to produce
	iim_pkg::in_item_t           record_queue[$];
	iim_pkg::out_item_t          row_expect_q[$];

	// shadow of the interval stores and the count register
	logic [iim_pkg::POS_IN_W-1:0] shadow_start[VREG_LIMIT];
	logic [iim_pkg::POS_IN_W-1:0] shadow_end[VREG_LIMIT];
	logic                        shadow_has[VREG_LIMIT];
	logic                        shadow_livein[VREG_LIMIT];
	int unsigned                 shadow_held = 0;
	logic [iim_pkg::CNT_W-1:0]   shadow_count = iim_pkg::VREG_COUNT_RST;

	bit                          rec_fire = 1'b0;
	bit                          quiet = 1'b0;
	int unsigned                 in_gap = 0;
	int unsigned                 out_gap = 0;
	int unsigned                 mismatches = 0;
	int unsigned                 records_taken = 0;
	int unsigned                 rows_checked = 0;
	int unsigned                 graphs_checked = 0;
	int unsigned                 count_writes = 0;
	int unsigned                 planned = 0;

	interval_interference_matrix DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	task report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// store one record and, when the graph is complete, compute its adjacency rows
	task store_record_build_rows(input iim_pkg::in_item_t rec);
		int unsigned n;
		int unsigned i;
		int unsigned j;
		iim_pkg::out_item_t row;
		if (shadow_count == 0)
			n = 1;
		else if (shadow_count > VREG_LIMIT)
			n = VREG_LIMIT;
		else
			n = shadow_count;
		if (shadow_held < VREG_LIMIT) begin
			shadow_start[shadow_held] = rec.live_start;
			shadow_end[shadow_held] = rec.live_end;
			shadow_has[shadow_held] = rec.has_interval;
			shadow_livein[shadow_held] = rec.live_in;
		end
		shadow_held = (shadow_held + 1) % 128;
		if (shadow_held >= n) begin
			for (i = 0; i < n; i++) begin
				row.row_index = i[iim_pkg::ROW_IDX_W-1:0];
				row.row_bits = '0;
				for (j = 0; j < n; j++) begin
					if (j != i) begin
						// overlap with inclusive ends, or both live on entry
						if ((shadow_has[i] && shadow_has[j] &&
								shadow_start[i] <= shadow_end[j] &&
								shadow_start[j] <= shadow_end[i]) ||
								(shadow_livein[i] && shadow_livein[j]))
							row.row_bits[j] = 1'b1;
					end
				end
				row.last_row = (i + 1 == n);
				row_expect_q.push_back(row);
			end
			shadow_held = 0;
		end
	endtask

	// random record; span sets how crowded the positions are
	function automatic iim_pkg::in_item_t make_record(input int unsigned span);
		iim_pkg::in_item_t r;
		int unsigned pick;
		int unsigned s;
		int unsigned e;
		pick = $urandom_range(0, 19);
		s = $urandom % span;
		e = s + $urandom_range(0, span / 4);
		if (e > 65535)
			e = 65535;
		r.live_start = s[iim_pkg::POS_IN_W-1:0];
		r.live_end = e[iim_pkg::POS_IN_W-1:0];
		// random ends that may put the start after the end, or one end pinned at an extreme
		if (pick == 0) begin
			r.live_start = iim_pkg::POS_IN_W'($urandom);
			r.live_end = iim_pkg::POS_IN_W'($urandom);
		end else if (pick == 1)
			r.live_start = '0;
		else if (pick == 2)
			r.live_end = '1;
		r.has_interval = ($urandom_range(0, 7) != 0);
		r.live_in = ($urandom_range(0, 3) == 0);
		return r;
	endfunction

	task push_record(input logic [iim_pkg::POS_IN_W-1:0] s,
			input logic [iim_pkg::POS_IN_W-1:0] e,
			input logic has, input logic lin);
		iim_pkg::in_item_t r;
		r.live_start = s;
		r.live_end = e;
		r.has_interval = has;
		r.live_in = lin;
		record_queue.push_back(r);
		planned++;
	endtask

	// wait until every item is taken and every row has come, then let the block settle
	task wait_idle;
		do
			@(posedge clk);
		while (record_queue.size() != 0 || in_valid || row_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_count(input logic [iim_pkg::CNT_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		shadow_count = value;
		count_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// record driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || rec_fire) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap--;
				end else if (record_queue.size() > 0) begin
					in_data <= record_queue.pop_front();
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 5) == 0)
						in_gap = $urandom_range(1, 8);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// row receiver with random stall bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_ready <= 1'b0;
				out_gap--;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0)
					out_gap = $urandom_range(1, 8);
			end
		end
	end

	// monitor: predict on each accepted record, check each accepted row
	always @(posedge clk) begin
		if (arst_n) begin
			rec_fire = in_valid && in_ready;
			if (rec_fire) begin
				records_taken++;
				store_record_build_rows(in_data);
			end
			if (out_valid && out_ready) begin
				if (row_expect_q.size() == 0) begin
					report_mismatch($sformatf("unexpected row %0d bits %h",
						out_data.row_index, out_data.row_bits));
				end else begin
					if (out_data.row_index != row_expect_q[0].row_index)
						report_mismatch($sformatf("row_index got %0d exp %0d",
							out_data.row_index, row_expect_q[0].row_index));
					if (out_data.row_bits != row_expect_q[0].row_bits)
						report_mismatch($sformatf("row %0d row_bits got %h exp %h",
							row_expect_q[0].row_index, out_data.row_bits,
							row_expect_q[0].row_bits));
					if (out_data.last_row != row_expect_q[0].last_row)
						report_mismatch($sformatf("row %0d last_row got %0b exp %0b",
							row_expect_q[0].row_index, out_data.last_row,
							row_expect_q[0].last_row));
					if (row_expect_q[0].last_row)
						graphs_checked++;
					void'(row_expect_q.pop_front());
					rows_checked++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int unsigned phase;
		int unsigned n;
		int unsigned graphs;
		int unsigned extra;
		int unsigned span;
		int unsigned k;
		logic [iim_pkg::CNT_W-1:0] count;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset count, partial load, then lower the count below what is held
		push_record(16'd1, 16'd9, 1'b1, 1'b0);
		push_record(16'd4, 16'd6, 1'b1, 1'b1);
		push_record(16'd20, 16'd30, 1'b1, 1'b1);
		wait_idle();
		write_count(7'd2);
		push_record(16'd0, 16'd0, 1'b0, 1'b0);
		wait_idle();

		// extreme positions and a start after its end
		write_count(7'd4);
		push_record(16'h0000, 16'h0000, 1'b1, 1'b0);
		push_record(16'hffff, 16'hffff, 1'b1, 1'b1);
		push_record(16'h0000, 16'hffff, 1'b1, 1'b1);
		push_record(16'h0008, 16'h0003, 1'b1, 1'b0);
		wait_idle();

		// zero count acts as one
		write_count(7'd0);
		push_record(16'h5555, 16'haaaa, 1'b1, 1'b1);
		push_record(16'haaaa, 16'h5555, 1'b0, 1'b0);
		wait_idle();
		write_count(7'd1);
		push_record(16'd3, 16'd3, 1'b0, 1'b1);
		wait_idle();

		// touching ends, adjacent ends, live-in without interval
		write_count(7'd3);
		push_record(16'd5, 16'd10, 1'b1, 1'b0);
		push_record(16'd10, 16'd20, 1'b1, 1'b0);
		push_record(16'd21, 16'd30, 1'b1, 1'b0);
		push_record(16'd5, 16'd10, 1'b0, 1'b1);
		push_record(16'd0, 16'd100, 1'b1, 1'b1);
		push_record(16'd7, 16'd7, 1'b0, 1'b0);
		wait_idle();

		// random phases: mostly small graphs, a couple at full size, leftovers carried over
		phase = 0;
		while (planned < RECORD_TARGET) begin
			phase++;
			if (phase == 2)
				count = 7'd127;
			else if (phase == 7)
				count = 7'd64;
			else begin
				case ($urandom_range(0, 9))
					0: count = 7'd0;
					1: count = 7'd1;
					2: count = iim_pkg::CNT_W'($urandom_range(13, 40));
					default: count = iim_pkg::CNT_W'($urandom_range(2, 12));
				endcase
			end
			write_count(count);
			if (count == 0)
				n = 1;
			else if (count > VREG_LIMIT)
				n = VREG_LIMIT;
			else
				n = count;
			graphs = (n > 12) ? 1 : $urandom_range(1, 4);
			extra = (n > 1 && $urandom_range(0, 1) == 1) ? $urandom_range(1, n - 1) : 0;
			case ($urandom_range(0, 3))
				0: span = 16;
				1: span = 256;
				2: span = 4096;
				default: span = 65536;
			endcase
			if (planned >= QUIET_AFTER)
				quiet = 1'b1;
			for (k = 0; k < graphs * n + extra && planned < RECORD_TARGET; k++) begin
				record_queue.push_back(make_record(span));
				planned++;
			end
			wait_idle();
		end

		wait_idle();
		if (row_expect_q.size() != 0)
			report_mismatch($sformatf("%0d rows never arrived", row_expect_q.size()));
		$display("covered %0d records, %0d rows in %0d graphs, %0d count writes",
			records_taken, rows_checked, graphs_checked, count_writes);
		$display("counts 0 to 127 incl. out of range values and changes in mid load");
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
